FILE: sv/bpid_pkg.sv
// Shared types and constants for the breath peak interval detector.
package bpid_pkg;

   // Default widths of the sample and timestamp fields
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT   = 32;

   // Configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PEAK_THRESHOLD  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_NEGATIVE_PEAKS  = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MIN_INTERVAL_MS = 2'd2;

   // Configuration reset values
   localparam logic signed [15:0] THRESHOLD_RESET    = -16'sd614;
   localparam logic              NEGATIVE_RESET     = 1'b1;
   localparam logic [15:0]       MIN_INTERVAL_RESET = 16'd1000;

   // Rate: 60000 ms/min * 256 (Q8.8) / interval, saturated
   localparam int DIV_STEPS = 24;
   localparam logic [DIV_STEPS-1:0] RATE_NUMERATOR = 24'd15360000;
   localparam logic [15:0] RATE_MAX = 16'hFFFF;
   // Any interval at or below this gives a quotient above RATE_MAX
   localparam int unsigned SAT_INTERVAL = 15360000 / 65536;

   // Queue between the front and the rate unit
   localparam int QUEUE_DEPTH = 2;

   // One classified sample on its way to the rate unit
   typedef struct packed {
      logic        detected;
      logic [15:0] count;
      logic [31:0] interval;
   } bpid_entry_type;

   // Rate unit sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } bpid_state_type;

endpackage

FILE: sv/bpid_front.sv
// Front end: configuration registers, sample window, peak detection and breath counting.
module bpid_front #(
   parameter int SAMPLE_BITS = bpid_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = bpid_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // sample channel
   input  logic                               req_push,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic [TIME_BITS-1:0]               req_timestamp_ms,
   // configuration channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpid_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_wdata,
   // toward the queue
   input  logic                               q_full,
   output logic                               q_push,
   output bpid_pkg::bpid_entry_type           q_wdata
);

   localparam int CmpBits = SAMPLE_BITS + 16;

   logic signed [15:0]            threshold_ff, threshold_in;
   logic                          negative_ff, negative_in;
   logic [15:0]                   min_interval_ff, min_interval_in;
   logic [SAMPLE_BITS-1:0]        older_ff, older_in;
   logic [SAMPLE_BITS-1:0]        middle_ff, middle_in;
   logic [TIME_BITS-1:0]          middle_time_ff, middle_time_in;
   logic                          armed_ff, armed_in;
   logic [TIME_BITS-1:0]          last_peak_ff, last_peak_in;
   logic [15:0]                   count_ff, count_in;
   logic [31:0]                   interval_ff, interval_in;

   logic                          accept;
   logic signed [CmpBits-1:0]     cur_x, old_x, nxt_x, thr_x;
   logic                          is_peak, rearm, detected;
   logic [TIME_BITS-1:0]          gap;
   logic [32:0]                   gap_wide;
   logic [32:0]                   min_wide;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !q_full;

   // Sign-extended copies for the comparisons
   assign cur_x = {{16{middle_ff[SAMPLE_BITS-1]}}, middle_ff};
   assign old_x = {{16{older_ff[SAMPLE_BITS-1]}}, older_ff};
   assign nxt_x = {{16{req_sample[SAMPLE_BITS-1]}}, req_sample};
   assign thr_x = {{SAMPLE_BITS{threshold_ff[15]}}, threshold_ff};

   // Peak and rearm tests on the middle sample
   always_comb begin
      if (negative_ff) begin
         is_peak = (cur_x < old_x) && (cur_x < nxt_x) && (cur_x < thr_x);
         rearm   = cur_x > thr_x;
      end else begin
         is_peak = (cur_x > old_x) && (cur_x > nxt_x) && (cur_x > thr_x);
         rearm   = cur_x < thr_x;
      end
   end

   // Modular gap since the last stored peak
   assign gap      = middle_time_ff - last_peak_ff;
   assign gap_wide = {{(33 - TIME_BITS){1'b0}}, gap};
   assign min_wide = {17'd0, min_interval_ff};

   // Next state
   always_comb begin
      threshold_in    = threshold_ff;
      negative_in     = negative_ff;
      min_interval_in = min_interval_ff;
      older_in        = older_ff;
      middle_in       = middle_ff;
      middle_time_in  = middle_time_ff;
      armed_in        = armed_ff;
      last_peak_in    = last_peak_ff;
      count_in        = count_ff;
      interval_in     = interval_ff;
      detected        = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            bpid_pkg::CSR_PEAK_THRESHOLD:  threshold_in    = csr_wdata;
            bpid_pkg::CSR_NEGATIVE_PEAKS:  negative_in     = csr_wdata[0];
            bpid_pkg::CSR_MIN_INTERVAL_MS: min_interval_in = csr_wdata;
            default: ;
         endcase
      end

      if (accept) begin
         if (is_peak) begin
            if (!armed_ff) begin
               armed_in = 1'b1;
               if (last_peak_ff != '0) begin
                  if (gap_wide > min_wide) begin
                     interval_in  = gap_wide[31:0];
                     count_in     = count_ff + 16'd1;
                     detected     = 1'b1;
                     last_peak_in = middle_time_ff;
                  end
               end else begin
                  last_peak_in = middle_time_ff;
               end
            end
         end else if (rearm) begin
            armed_in = 1'b0;
         end
         older_in       = middle_ff;
         middle_in      = req_sample;
         middle_time_in = req_timestamp_ms;
      end
   end

   // Result beat toward the rate unit
   assign q_push            = accept;
   assign q_wdata.detected  = detected;
   assign q_wdata.count     = count_in;
   assign q_wdata.interval  = interval_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= bpid_pkg::THRESHOLD_RESET;
         negative_ff     <= bpid_pkg::NEGATIVE_RESET;
         min_interval_ff <= bpid_pkg::MIN_INTERVAL_RESET;
         older_ff        <= '0;
         middle_ff       <= '0;
         middle_time_ff  <= '0;
         armed_ff        <= 1'b0;
         last_peak_ff    <= '0;
         count_ff        <= '0;
         interval_ff     <= '0;
      end else begin
         threshold_ff    <= threshold_in;
         negative_ff     <= negative_in;
         min_interval_ff <= min_interval_in;
         older_ff        <= older_in;
         middle_ff       <= middle_in;
         middle_time_ff  <= middle_time_in;
         armed_ff        <= armed_in;
         last_peak_ff    <= last_peak_in;
         count_ff        <= count_in;
         interval_ff     <= interval_in;
      end
   end

endmodule

FILE: sv/bpid_queue.sv
// Short queue of classified samples between the front end and the rate unit.
module bpid_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  bpid_pkg::bpid_entry_type wdata,
   output logic                     full,
   input  logic                     pop,
   output bpid_pkg::bpid_entry_type rdata,
   output logic                     empty
);

   localparam int Depth   = bpid_pkg::QUEUE_DEPTH;
   localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

   bpid_pkg::bpid_entry_type mem_ff [Depth];
   logic [PtrBits-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]         fill_ff, fill_in;
   logic                     do_push, do_pop;

   assign full    = fill_ff == (PtrBits + 1)'(Depth);
   assign empty   = fill_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer wrap and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: sv/bpid_rate.sv
// Rate unit: bit-serial divide for the breath rate and the result output register.
module bpid_rate (
   input  logic                     clock,
   input  logic                     reset,
   // from the queue
   input  logic                     q_empty,
   input  bpid_pkg::bpid_entry_type q_rdata,
   output logic                     q_pop,
   // result channel
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_breath_detected,
   output logic [15:0]              rsp_breath_count,
   output logic [31:0]              rsp_latest_interval_ms,
   output logic [15:0]              rsp_breath_rate_q8
);

   localparam int Steps    = bpid_pkg::DIV_STEPS;
   localparam int StepBits = $clog2(Steps);

   bpid_pkg::bpid_state_type state_ff, state_in;
   bpid_pkg::bpid_entry_type entry_ff, entry_in;
   bpid_pkg::bpid_entry_type out_entry_ff, out_entry_in;
   logic [15:0]              rate_ff, rate_in;
   logic [15:0]              out_rate_ff, out_rate_in;
   logic                     out_valid_ff, out_valid_in;
   logic [Steps-1:0]         dividend_ff, dividend_in;
   logic [31:0]              rem_ff, rem_in;
   logic [StepBits-1:0]      step_ff, step_in;

   logic                     load, out_load, last_step, short_path;
   logic [32:0]              trial, diff;
   logic                     ge;

   // A beat skips the divide when fewer than two breaths or the rate saturates
   assign short_path = (q_rdata.count < 16'd2)
                    || (q_rdata.interval <= 32'(bpid_pkg::SAT_INTERVAL));
   assign last_step  = step_ff == StepBits'(Steps - 1);

   // One restoring division step
   assign trial = {rem_ff, dividend_ff[Steps-1]};
   assign diff  = trial - {1'b0, entry_ff.interval};
   assign ge    = !diff[32];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpid_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = short_path ? bpid_pkg::ST_DONE : bpid_pkg::ST_DIVIDE;
            end
         end
         bpid_pkg::ST_DIVIDE: begin
            if (last_step) begin
               state_in = bpid_pkg::ST_DONE;
            end
         end
         bpid_pkg::ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               state_in = bpid_pkg::ST_IDLE;
            end
         end
         default: state_in = bpid_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      load     = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         bpid_pkg::ST_IDLE:   load     = !q_empty;
         bpid_pkg::ST_DIVIDE: ;
         bpid_pkg::ST_DONE:   out_load = !out_valid_ff || rsp_pop;
         default: ;
      endcase
   end

   assign q_pop = load;

   // Datapath
   always_comb begin
      entry_in     = entry_ff;
      rate_in      = rate_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      out_entry_in = out_entry_ff;
      out_rate_in  = out_rate_ff;
      out_valid_in = out_valid_ff;

      if (load) begin
         entry_in    = q_rdata;
         rate_in     = (q_rdata.count < 16'd2) ? 16'd0 : bpid_pkg::RATE_MAX;
         dividend_in = bpid_pkg::RATE_NUMERATOR;
         rem_in      = '0;
         step_in     = '0;
      end

      if (state_ff == bpid_pkg::ST_DIVIDE) begin
         rem_in      = ge ? diff[31:0] : trial[31:0];
         dividend_in = {dividend_ff[Steps-2:0], ge};
         step_in     = step_ff + 1'b1;
         if (last_step) begin
            rate_in = dividend_in[15:0];
         end
      end

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_entry_in = entry_ff;
         out_rate_in  = rate_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpid_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      rate_ff      <= rate_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      out_entry_ff <= out_entry_in;
      out_rate_ff  <= out_rate_in;
   end

   assign rsp_empty              = !out_valid_ff;
   assign rsp_breath_detected    = out_entry_ff.detected;
   assign rsp_breath_count       = out_entry_ff.count;
   assign rsp_latest_interval_ms = out_entry_ff.interval;
   assign rsp_breath_rate_q8     = out_rate_ff;

endmodule

FILE: sv/breath_peak_interval_detector.sv
// Top level of the breath peak interval detector.
//
// Samples enter on a queue-style port: a beat is taken when req_push is high
// and req_full low. The front end tests the middle of a three-sample window
// for a peak, counts breaths and passes one entry per sample into a two-deep
// queue. The rate unit divides 15360000 by the latest interval one quotient
// bit per cycle and places the result in an output register.
// Results leave on a queue-style port: rsp_empty low means a result is shown,
// rsp_pop high takes it.
// No divide is needed when fewer than two breaths are counted or the rate
// saturates. Sustained throughput for samples that need the divide is set
// by the serial divider, which loads an entry, runs 24 divide steps and
// loads the output register before it takes the next entry; the front end
// takes a sample per cycle until the queue fills.
// While the receiver stalls the result register holds, the rate unit waits
// with its next result, and req_full rises once the queue is full.
// Configuration writes (csr_valid, always ready) go straight to the front end.
// Synchronous reset restores register defaults and empties the pipeline.
module breath_peak_interval_detector #(
   parameter int SAMPLE_BITS = bpid_pkg::SAMPLE_BITS_DEFAULT,
   parameter int TIME_BITS   = bpid_pkg::TIME_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic [TIME_BITS-1:0]               req_timestamp_ms,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_breath_detected,
   output logic [15:0]                        rsp_breath_count,
   output logic [31:0]                        rsp_latest_interval_ms,
   output logic [15:0]                        rsp_breath_rate_q8,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpid_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_wdata
);

   logic                     q_push, q_pop, q_full, q_empty;
   bpid_pkg::bpid_entry_type q_wdata, q_rdata;

   assign req_full = q_full;

   bpid_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_sample       (req_sample),
      .req_timestamp_ms (req_timestamp_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   bpid_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   bpid_rate u_rate (
      .clock                  (clock),
      .reset                  (reset),
      .q_empty                (q_empty),
      .q_rdata                (q_rdata),
      .q_pop                  (q_pop),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_breath_detected    (rsp_breath_detected),
      .rsp_breath_count       (rsp_breath_count),
      .rsp_latest_interval_ms (rsp_latest_interval_ms),
      .rsp_breath_rate_q8     (rsp_breath_rate_q8)
   );

endmodule

FILE: sv/bpid_checker.sv
// Port-level checks on the result channel, bound to the top level.
module bpid_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_breath_detected,
   input logic [15:0] rsp_breath_count,
   input logic [31:0] rsp_latest_interval_ms,
   input logic [15:0] rsp_breath_rate_q8
);

   // Reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // A waiting beat holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_breath_count)
         && $stable(rsp_latest_interval_ms) && $stable(rsp_breath_rate_q8)))
      else $error("waiting result changed or vanished");

   // No rate before two breaths
   a_rate_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_breath_count < 16'd2) |-> rsp_breath_rate_q8 == 16'd0)
      else $error("nonzero rate with fewer than two breaths");

   // A new breath always carries a nonzero gap
   a_gap: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_breath_detected) |-> rsp_latest_interval_ms != 32'd0)
      else $error("breath reported with zero interval");

endmodule

bind breath_peak_interval_detector bpid_checker u_bpid_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_empty              (rsp_empty),
   .rsp_pop                (rsp_pop),
   .rsp_breath_detected    (rsp_breath_detected),
   .rsp_breath_count       (rsp_breath_count),
   .rsp_latest_interval_ms (rsp_latest_interval_ms),
   .rsp_breath_rate_q8     (rsp_breath_rate_q8)
);
